// ===== rtl/core/majority_clocked_lfsr_keystream_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Keystream unit assertion macros
// Shared concurrent assertion wrappers for the keystream unit RTL.
// ----------------------------------------------------------------------------
`ifndef MAJORITY_CLOCKED_LFSR_KEYSTREAM_UNIT_DEFINES_SVH
`define MAJORITY_CLOCKED_LFSR_KEYSTREAM_UNIT_DEFINES_SVH

// Checked on every rising clock edge outside of reset.
`define MCLK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define MCLK_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mclk_pkg.sv =====
// ----------------------------------------------------------------------------
// Keystream unit package
// Register state type, key loading and the majority clocking step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mclk_pkg;

	localparam int LEN_A     = 19;
	localparam int LEN_B     = 22;
	localparam int LEN_C     = 23;
	localparam int KEY_W     = 64;
	localparam int KEY_TOP_A = 63;
	localparam int KEY_TOP_B = 44;
	localparam int KEY_TOP_C = 22;
	localparam int CLK_A     = 10;
	localparam int CLK_B     = 11;
	localparam int CLK_C     = 12;
	localparam int TAP_A     = 5;
	localparam int TAP_C     = 15;
	localparam int BYTE_W    = 8;

	typedef struct packed {
		logic [LEN_C-1:0] c;
		logic [LEN_B-1:0] b;
		logic [LEN_A-1:0] a;
	} lfsr_t;

	function automatic lfsr_t load_key(input logic [KEY_W-1:0] key);
		lfsr_t st;
		for (int i = 0; i < LEN_A; i++) begin
			st.a[i] = key[KEY_TOP_A - i];
		end
		for (int i = 0; i < LEN_B; i++) begin
			st.b[i] = key[KEY_TOP_B - i];
		end
		for (int i = 0; i < LEN_C; i++) begin
			st.c[i] = key[KEY_TOP_C - i];
		end
		return st;
	endfunction

	function automatic lfsr_t clock_step(input lfsr_t st);
		lfsr_t nx;
		logic  ca;
		logic  cb;
		logic  cc;
		logic  maj;
		nx  = st;
		ca  = st.a[CLK_A];
		cb  = st.b[CLK_B];
		cc  = st.c[CLK_C];
		maj = (ca & cb) | (ca & cc) | (cb & cc);
		if (ca == maj) begin
			nx.a = {st.a[0] ^ st.a[1] ^ st.a[2] ^ st.a[TAP_A], st.a[LEN_A-1:1]};
		end
		if (cb == maj) begin
			nx.b = {st.b[0] ^ st.b[1], st.b[LEN_B-1:1]};
		end
		if (cc == maj) begin
			nx.c = {st.c[0] ^ st.c[1] ^ st.c[2] ^ st.c[TAP_C], st.c[LEN_C-1:1]};
		end
		return nx;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mclk_byte_gen.sv =====
// ----------------------------------------------------------------------------
// Keystream byte generator
// Eight majority clocking steps that yield one keystream byte and the state
// that follows it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mclk_byte_gen (
	input  mclk_pkg::lfsr_t  state_in,
	output mclk_pkg::lfsr_t  state_out,
	output logic [7:0]       ks_byte
);
	import mclk_pkg::*;

	always_comb begin
		lfsr_t st;
		st = state_in;
		for (int i = 0; i < BYTE_W; i++) begin
			ks_byte[BYTE_W-1-i] = st.a[0] ^ st.b[0] ^ st.c[0];
			st = clock_step(st);
		end
		state_out = st;
	end

endmodule

`default_nettype wire

// ===== rtl/core/mclk_reload.sv =====
// ----------------------------------------------------------------------------
// Restart state register
// Holds the register contents and keystream byte that a restart produces,
// computed from the key when it is written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mclk_reload (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [63:0]      cfg_wdata,
	output mclk_pkg::lfsr_t  rst_state,
	output logic [7:0]       rst_ks
);
	import mclk_pkg::*;

	lfsr_t      loaded;
	lfsr_t      gen_state;
	logic [7:0] gen_ks;
	lfsr_t      rst_state_q;
	logic [7:0] rst_ks_q;

	assign loaded = load_key(cfg_wdata);

	mclk_byte_gen u_gen (
		.state_in  (loaded),
		.state_out (gen_state),
		.ks_byte   (gen_ks)
	);

	// The reset key of zero leaves every register and the first byte at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rst_state_q <= '0;
			rst_ks_q    <= '0;
		end else if (cfg_we) begin
			rst_state_q <= gen_state;
			rst_ks_q    <= gen_ks;
		end
	end

	assign rst_state = rst_state_q;
	assign rst_ks    = rst_ks_q;

endmodule

`default_nettype wire

// ===== rtl/core/majority_clocked_lfsr_keystream_unit.sv =====
// ----------------------------------------------------------------------------
// Majority clocked keystream unit
// Byte-wide stream cipher built on three majority clocked shift registers.
// ----------------------------------------------------------------------------
// The unit takes one data byte per cycle while the output side is not stalled,
// and returns it XORed with the current keystream byte, together with that
// keystream byte. A request is held in an input register; when the output
// register can take it, eight majority clocking steps produce the following
// keystream byte while the result moves to the output register, so the unit
// sustains one byte per cycle unless the output stalls; this eight-step
// generator ahead of the state register sets the clock rate. A key write
// precomputes the state a restart begins from, so a restart request needs no
// extra steps. A new key takes effect at the next restart request.
`timescale 1ns / 1ps
`default_nettype none

`include "majority_clocked_lfsr_keystream_unit_defines.svh"

module majority_clocked_lfsr_keystream_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [7:0] cipher_byte, [15:8] keystream_byte
);
	import mclk_pkg::*;

	lfsr_t      rst_state;
	logic [7:0] rst_ks;
	lfsr_t      lfsr_q;
	logic [7:0] ks_q;
	logic       valid_s1;
	logic       restart_s1;
	logic [7:0] data_s1;
	logic       out_valid_q;
	logic [7:0] cipher_q;
	logic [7:0] ks_out_q;
	lfsr_t      sel_state;
	logic [7:0] sel_ks;
	lfsr_t      nxt_state;
	logic [7:0] nxt_ks;
	logic       adv;
	logic       s_accept;

	mclk_reload u_reload (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rst_state (rst_state),
		.rst_ks    (rst_ks)
	);

	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	assign sel_state = restart_s1 ? rst_state : lfsr_q;
	assign sel_ks    = restart_s1 ? rst_ks : ks_q;

	mclk_byte_gen u_gen (
		.state_in  (sel_state),
		.state_out (nxt_state),
		.ks_byte   (nxt_ks)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			restart_s1 <= s_axis_tuser;
			data_s1    <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= '0;
			ks_q   <= '0;
		end else if (adv) begin
			lfsr_q <= nxt_state;
			ks_q   <= nxt_ks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cipher_q <= data_s1 ^ sel_ks;
			ks_out_q <= sel_ks;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {ks_out_q, cipher_q};

	`MCLK_ASSERT(a_adv_fills_out, adv |=> m_axis_tvalid, "Advanced request did not reach the output.")
	`MCLK_ASSERT(a_cipher_xor, adv |=> (m_axis_tdata[7:0] ^ m_axis_tdata[15:8]) == $past(data_s1), "Cipher byte does not match data XOR keystream.")
	`MCLK_ASSERT(a_s1_hold, (valid_s1 && !adv) |=> (valid_s1 && $stable(data_s1) && $stable(restart_s1)), "Stalled request was lost or changed.")

endmodule

`default_nettype wire

// ===== tb/tb_majority_clocked_lfsr_keystream_unit.sv =====
// ----------------------------------------------------------------------------
// Keystream unit testbench
// Drives byte requests with random restarts and key changes into the unit,
// predicts each cipher and keystream byte with an independent model of the three
// majority clocked shift registers or a directed table, and checks every result
// in order while both stream sides idle and stall at random except in the first phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_majority_clocked_lfsr_keystream_unit;

	localparam int CYCLE_LIMIT = 200000;
	localparam int NUM_DIRECTED = 19;
	localparam int NUM_PHASES = 5;

	typedef struct packed {
		bit [7:0] cipher;
		bit [7:0] ks;
	} cipher_out_t;

	typedef struct packed {
		bit        key_wr;
		bit [63:0] key;
		bit        restart;
		bit [7:0]  data;
		bit        typed;
		bit [7:0]  want_cipher;
		bit [7:0]  want_ks;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [63:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;  // [7:0] data_byte
	logic        s_axis_tuser = 1'b0;  // [0] restart
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;  // [7:0] cipher_byte, [15:8] keystream_byte

	bit [18:0] pred_a;
	bit [21:0] pred_b;
	bit [22:0] pred_c;
	bit [7:0]  pred_ks;
	bit [63:0] pred_key;

	cipher_out_t pending_results[$];
	directed_row_t directed_rows[NUM_DIRECTED];
	bit [63:0] phase_keys[NUM_PHASES];
	int phase_items[NUM_PHASES];

	int mismatches = 0;
	int cycle_count = 0;
	bit send_idle_on = 1'b0;
	bit recv_stall_on = 1'b0;

	majority_clocked_lfsr_keystream_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	// Each generated bit is taken before the majority step that follows it.
	function automatic bit [7:0] produce_keystream_byte();
		bit [7:0] ks;
		bit ca;
		bit cb;
		bit cc;
		bit maj;
		ks = '0;
		for (int i = 0; i < 8; i++) begin
			ks[7 - i] = pred_a[0] ^ pred_b[0] ^ pred_c[0];
			ca = pred_a[10];
			cb = pred_b[11];
			cc = pred_c[12];
			maj = (ca & cb) | (ca & cc) | (cb & cc);
			if (ca == maj) begin
				pred_a = {pred_a[0] ^ pred_a[1] ^ pred_a[2] ^ pred_a[5], pred_a[18:1]};
			end
			if (cb == maj) begin
				pred_b = {pred_b[0] ^ pred_b[1], pred_b[21:1]};
			end
			if (cc == maj) begin
				pred_c = {pred_c[0] ^ pred_c[1] ^ pred_c[2] ^ pred_c[15], pred_c[22:1]};
			end
		end
		return ks;
	endfunction

	task automatic send_byte(input bit restart, input bit [7:0] data, input bit typed,
			input bit [7:0] want_cipher, input bit [7:0] want_ks);
		cipher_out_t res;
		while (send_idle_on && ($urandom_range(0, 99) < 35)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= restart;
		s_axis_tdata <= data;
		do @(posedge clk); while (!s_axis_tready);
		if (restart) begin
			for (int i = 0; i < 19; i++) begin
				pred_a[i] = pred_key[63 - i];
			end
			for (int i = 0; i < 22; i++) begin
				pred_b[i] = pred_key[44 - i];
			end
			for (int i = 0; i < 23; i++) begin
				pred_c[i] = pred_key[22 - i];
			end
			pred_ks = produce_keystream_byte();
		end
		res.ks = pred_ks;
		res.cipher = data ^ pred_ks;
		pred_ks = produce_keystream_byte();
		if (typed) begin
			res.cipher = want_cipher;
			res.ks = want_ks;
		end
		pending_results.insert(pending_results.size(), res);
	endtask

	// The key may only change while no request is in flight.
	task automatic write_key_seed(input bit [63:0] key);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= key;
		@(posedge clk);
		cfg_we <= 1'b0;
		pred_key = key;
	endtask

	always @(posedge clk) begin
		cipher_out_t exp_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result expected none actual %h", $time, m_axis_tdata);
				mismatches++;
			end else begin
				exp_res = pending_results[0];
				pending_results.delete(0);
				if (m_axis_tdata[7:0] !== exp_res.cipher) begin
					$display("%0t: cipher_byte expected %h actual %h", $time,
						exp_res.cipher, m_axis_tdata[7:0]);
					mismatches++;
				end
				if (m_axis_tdata[15:8] !== exp_res.ks) begin
					$display("%0t: keystream_byte expected %h actual %h", $time,
						exp_res.ks, m_axis_tdata[15:8]);
					mismatches++;
				end
			end
		end
		m_axis_tready <= !(recv_stall_on && ($urandom_range(0, 99) < 35));
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_majority_clocked_lfsr_keystream_unit failed");
			$finish;
		end
	end

	initial begin
		bit restart;
		directed_rows = '{
			'{1'b0, 64'h0, 1'b0, 8'h00, 1'b1, 8'h00, 8'h00},
			'{1'b0, 64'h0, 1'b0, 8'hFF, 1'b1, 8'hFF, 8'h00},
			'{1'b0, 64'h0, 1'b0, 8'hA5, 1'b1, 8'hA5, 8'h00},
			'{1'b0, 64'h0, 1'b1, 8'h5A, 1'b1, 8'h5A, 8'h00},
			'{1'b0, 64'h0, 1'b0, 8'hC3, 1'b1, 8'hC3, 8'h00},
			'{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h3C, 1'b1, 8'h3C, 8'h00},
			'{1'b0, 64'h0, 1'b1, 8'h00, 1'b0, 8'h00, 8'h00},
			'{1'b0, 64'h0, 1'b0, 8'hFF, 1'b0, 8'h00, 8'h00},
			'{1'b0, 64'h0, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
			'{1'b0, 64'h0, 1'b1, 8'h81, 1'b0, 8'h00, 8'h00},
			'{1'b0, 64'h0, 1'b1, 8'h7E, 1'b0, 8'h00, 8'h00},
			'{1'b1, 64'h8000_0000_0000_0001, 1'b1, 8'h00, 1'b0, 8'h00, 8'h00},
			'{1'b0, 64'h0, 1'b0, 8'hFF, 1'b0, 8'h00, 8'h00},
			'{1'b1, 64'h0123_4567_89AB_CDEF, 1'b0, 8'h55, 1'b0, 8'h00, 8'h00},
			'{1'b0, 64'h0, 1'b1, 8'hAA, 1'b0, 8'h00, 8'h00},
			'{1'b0, 64'h0, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00},
			'{1'b0, 64'h0, 1'b0, 8'hFF, 1'b0, 8'h00, 8'h00},
			'{1'b1, 64'h0, 1'b1, 8'h12, 1'b1, 8'h12, 8'h00},
			'{1'b0, 64'h0, 1'b0, 8'hFF, 1'b1, 8'hFF, 8'h00}
		};
		phase_keys[0] = {$urandom, $urandom};
		phase_keys[1] = 64'hFFFF_FFFF_FFFF_FFFF;
		phase_keys[2] = {$urandom, $urandom};
		phase_keys[3] = 64'h0;
		phase_keys[4] = {$urandom, $urandom};
		phase_items = '{300, 250, 300, 100, 300};

		pred_a = '0;
		pred_b = '0;
		pred_c = '0;
		pred_ks = '0;
		pred_key = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_on = 1'b1;
		recv_stall_on = 1'b1;
		foreach (directed_rows[r]) begin
			if (directed_rows[r].key_wr) begin
				write_key_seed(directed_rows[r].key);
			end
			send_byte(directed_rows[r].restart, directed_rows[r].data, directed_rows[r].typed,
				directed_rows[r].want_cipher, directed_rows[r].want_ks);
		end

		// The first phase runs at full rate on both sides.
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_key_seed(phase_keys[p]);
			send_idle_on = (p != 0);
			recv_stall_on = (p != 0);
			for (int n = 0; n < phase_items[p]; n++) begin
				restart = (n == 0) || ($urandom_range(0, 99) < 4);
				send_byte(restart, 8'($urandom_range(0, 255)), 1'b0, 8'h00, 8'h00);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_majority_clocked_lfsr_keystream_unit passed");
		end else begin
			$display("tb_majority_clocked_lfsr_keystream_unit failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mclk_pkg.sv
rtl/core/mclk_byte_gen.sv
rtl/core/mclk_reload.sv
rtl/core/majority_clocked_lfsr_keystream_unit.sv
tb/tb_majority_clocked_lfsr_keystream_unit.sv
